// ===== src/hms_pkg.sv =====
// ----------------------------------------------------------------------------
// hms_pkg
// Shared types and constants for the 24-hour clock with serial time setting.
// ----------------------------------------------------------------------------
`default_nettype none

package hms_pkg;

  localparam logic [7:0] TPS_RESET = 8'd61;

  localparam logic [5:0] SEC_WRAP  = 6'd60;
  localparam logic [6:0] MIN_WRAP  = 7'd60;
  localparam logic [6:0] HOUR_WRAP = 7'd24;
  localparam logic [6:0] HOUR_MAX  = 7'd23;
  localparam logic [6:0] MIN_MAX   = 7'd59;

  // Request kinds.
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_BYTE = 1'b1;

  // Serial command bytes and the ASCII digit range.
  localparam logic [7:0] CMD_START = 8'h69;  // 'i'
  localparam logic [7:0] CMD_STOP  = 8'h73;  // 's'
  localparam logic [7:0] CMD_SET   = 8'h6F;  // 'o'
  localparam logic [7:0] CHAR_0    = 8'h30;
  localparam logic [7:0] CHAR_9    = 8'h39;

  // Digit entry positions.
  localparam logic [1:0] POS_HOUR_TENS = 2'd0;
  localparam logic [1:0] POS_HOUR_ONES = 2'd1;
  localparam logic [1:0] POS_MIN_TENS  = 2'd2;
  localparam logic [1:0] POS_MIN_ONES  = 2'd3;

  // Event codes.
  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_BAD_HOUR = 2'd1;
  localparam logic [1:0] EV_BAD_MIN  = 2'd2;
  localparam logic [1:0] EV_SET_DONE = 2'd3;

  typedef struct packed {
    logic [7:0] tick_count;
    logic [5:0] seconds;
    logic [6:0] minutes;
    logic [6:0] hours;
    logic       run_flag;
    logic       set_flag;
    logic [1:0] digit_pos;
    logic [3:0] last_digit;
  } hms_state_t;

  typedef struct packed {
    logic       show_time;
    logic [1:0] event_res;
  } hms_status_t;

endpackage

`default_nettype wire

// ===== src/hms_if.sv =====
// ----------------------------------------------------------------------------
// hms_if
// Valid/ready channels for the request items and the result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface hms_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface hms_out_if;
  logic       valid;
  logic       ready;
  logic       show_time;
  logic [6:0] hours;
  logic [6:0] minutes;
  logic [5:0] seconds;
  logic       running;
  logic       setting_mode;
  logic [1:0] entry_position;
  logic [1:0] event_res;

  modport source (output valid, output show_time, output hours, output minutes,
                  output seconds, output running, output setting_mode,
                  output entry_position, output event_res, input ready);
  modport sink   (input valid, input show_time, input hours, input minutes,
                  input seconds, input running, input setting_mode,
                  input entry_position, input event_res, output ready);
endinterface

`default_nettype wire

// ===== src/hms_step.sv =====
// ----------------------------------------------------------------------------
// hms_step
// Next-state logic for one item: prescaler, time rollover, commands and digit entry.
// ----------------------------------------------------------------------------
`default_nettype none

module hms_step (
  input  hms_pkg::hms_state_t  cur,
  input  logic [7:0]           ticks_per_second,
  input  logic                 req_type,
  input  logic [7:0]           rx_byte,
  output hms_pkg::hms_state_t  nxt,
  output hms_pkg::hms_status_t status
);
  import hms_pkg::*;

  logic [8:0] tick_inc;
  logic       second_done;
  logic [5:0] sec_inc;
  logic [6:0] min_adv;
  logic [6:0] hour_adv;
  logic [5:0] sec_new;
  logic [6:0] min_new;
  logic [6:0] hour_new;
  logic [3:0] digit;
  logic [6:0] digit_x10;
  logic [6:0] hour_sum;
  logic [6:0] min_sum;

  assign tick_inc    = {1'b0, cur.tick_count} + 9'd1;
  assign second_done = (tick_inc >= {1'b0, ticks_per_second});

  // One-second advance, each wrap checked in turn as the counters cascade.
  always_comb begin
    sec_inc  = cur.seconds + 6'd1;
    min_adv  = cur.minutes;
    hour_adv = cur.hours;
    sec_new  = sec_inc;
    if (sec_inc == SEC_WRAP) begin
      sec_new = '0;
      min_adv = cur.minutes + 7'd1;
    end
    min_new = min_adv;
    if (min_adv == MIN_WRAP) begin
      min_new  = '0;
      hour_adv = cur.hours + 7'd1;
    end
    hour_new = hour_adv;
    if (hour_adv == HOUR_WRAP) begin
      hour_new = '0;
    end
  end

  // A byte that is not a digit reuses the last digit received.
  assign digit     = (rx_byte inside {[CHAR_0:CHAR_9]}) ? 4'(rx_byte - CHAR_0)
                                                        : cur.last_digit;
  assign digit_x10 = ({3'b000, digit} << 3) + ({3'b000, digit} << 1);
  assign hour_sum  = cur.hours + {3'b000, digit};
  assign min_sum   = cur.minutes + {3'b000, digit};

  always_comb begin
    nxt              = cur;
    status.show_time = 1'b0;
    status.event_res = EV_NONE;
    if (req_type == REQ_TICK) begin
      if (cur.run_flag) begin
        if (second_done) begin
          nxt.tick_count   = '0;
          nxt.seconds      = sec_new;
          nxt.minutes      = min_new;
          nxt.hours        = hour_new;
          status.show_time = 1'b1;
        end else begin
          nxt.tick_count = tick_inc[7:0];
        end
      end
    end else begin
      status.show_time = 1'b1;
      if (!cur.set_flag) begin
        if (rx_byte == CMD_START) begin
          nxt.run_flag = 1'b1;
        end else if (rx_byte == CMD_STOP) begin
          nxt.run_flag = 1'b0;
        end else if (rx_byte == CMD_SET) begin
          nxt.set_flag = 1'b1;
        end
      end else begin
        nxt.run_flag   = 1'b0;
        nxt.last_digit = digit;
        case (cur.digit_pos)
          POS_HOUR_TENS: begin
            nxt.hours     = digit_x10;
            nxt.digit_pos = POS_HOUR_ONES;
          end
          POS_HOUR_ONES: begin
            nxt.hours = hour_sum;
            if (hour_sum > HOUR_MAX) begin
              nxt.digit_pos    = POS_HOUR_TENS;
              status.event_res = EV_BAD_HOUR;
            end else begin
              nxt.digit_pos = POS_MIN_TENS;
            end
          end
          POS_MIN_TENS: begin
            nxt.minutes   = digit_x10;
            nxt.digit_pos = POS_MIN_ONES;
          end
          default: begin
            nxt.minutes = min_sum;
            if (min_sum > MIN_MAX) begin
              nxt.digit_pos    = POS_MIN_TENS;
              status.event_res = EV_BAD_MIN;
            end else begin
              nxt.digit_pos    = POS_HOUR_TENS;
              nxt.set_flag     = 1'b0;
              status.event_res = EV_SET_DONE;
            end
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/hms_clock_with_serial_set_top.sv =====
// A result item is shown in the cycle after its request item is accepted.
// Throughput: one item per cycle while the output is taken; the whole update of the clock state is one
// combinational pass between the state register and the result register.
// The input is ready whenever the result register is empty or being taken.
// Reset (synchronous, active low) clears the time, stops the clock, leaves set
// mode and loads a prescaler of 61 ticks per second.
// ----------------------------------------------------------------------------
// hms_clock_with_serial_set_top
// 24-hour clock driven by timer ticks and serial command or digit bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module hms_clock_with_serial_set_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  hms_in_if.sink      in_ch,
  hms_out_if.source   out_ch
);
  import hms_pkg::*;

  logic [7:0]  tps_r;
  hms_state_t  state_r;
  hms_state_t  state_nxt;
  hms_status_t status_nxt;
  logic        out_valid_r;
  logic        in_fire;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  hms_step u_step (
    .cur              (state_r),
    .ticks_per_second (tps_r),
    .req_type         (in_ch.req_type),
    .rx_byte          (in_ch.rx_byte),
    .nxt              (state_nxt),
    .status           (status_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_RESET;
    end else if (cfg_we) begin
      tps_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= in_ch.valid;
    end
  end

  // The result register reflects the state just after the accepted item.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_ch.show_time      <= status_nxt.show_time;
      out_ch.hours          <= state_nxt.hours;
      out_ch.minutes        <= state_nxt.minutes;
      out_ch.seconds        <= state_nxt.seconds;
      out_ch.running        <= state_nxt.run_flag;
      out_ch.setting_mode   <= state_nxt.set_flag;
      out_ch.entry_position <= state_nxt.digit_pos;
      out_ch.event_res      <= status_nxt.event_res;
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule

`default_nettype wire
